@@ hdl/sfht_pkg.sv @@
// sfht_pkg: shared types and constants for the smallest-free handle table
// depends on: nothing
package sfht_pkg;

  localparam int unsigned ID_W     = 7;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned ID_SPACE = 1 << ID_W;

  // operation codes on the input beat
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_e;

  // status codes on the output beat
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic            step;    // pop head, shift all cells one place down
    logic            keep;    // on a step, recirculate the head to the tail
    logic            append;  // write wr_id at the tail
    logic [ID_W-1:0] wr_id;
  } cell_ctrl_t;

endpackage

@@ hdl/smallest_free_handle_table_unit.sv @@
// smallest_free_handle_table_unit: top level of the smallest-free handle table
// depends on: sfht_pkg, sfht_cell, sfht_id_map
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o   | opcode_i, handle_id_i
//  out     | output    | out_valid_o/out_ready_i | status_o, result_id_o, position_o
//
// allocate, a missing id or an unknown opcode: the beat goes through the decode and finish
// states to the result register, then the unit is back in idle for a new input beat.
// release or lookup of a live id: decode, scan, finish; the live list rotates once
// through the cell chain, one cell per cycle, and the head cell is compared each cycle.
// reset clears the entry count and the id bitmap at once; no clearing pass.
// a result waits in the output register while the next beat is taken; an operation
// that finishes while that register is still full holds until it drains.
module smallest_free_handle_table_unit #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sfht_pkg::OP_W-1:0] opcode_i,
  input  logic [sfht_pkg::ID_W-1:0] handle_id_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sfht_pkg::ST_W-1:0]  status_o,
  output logic [sfht_pkg::ID_W-1:0]  result_id_o,
  output logic [sfht_pkg::POS_W-1:0] position_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned ID_W  = sfht_pkg::ID_W;
  localparam int unsigned POS_W = sfht_pkg::POS_W;
  localparam int unsigned ST_W  = sfht_pkg::ST_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e                state_q, state_d;
  logic [sfht_pkg::OP_W-1:0] op_q, op_d;
  logic [ID_W-1:0]       key_q, key_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      remain_q, remain_d;
  logic [IDX_W-1:0]      pop_q, pop_d;
  logic [ST_W-1:0]       res_st_q, res_st_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  logic [POS_W-1:0]      res_pos_q, res_pos_d;
  logic                  out_valid_q, out_valid_d;
  logic [ST_W-1:0]       status_q, status_d;
  logic [ID_W-1:0]       result_id_q, result_id_d;
  logic [POS_W-1:0]      position_q, position_d;

  sfht_pkg::cell_ctrl_t  cell_ctrl;
  logic [ID_W-1:0]       id_chain [MAX_ENTRIES];
  logic                  head_hit;
  logic                  map_set, map_clr;
  logic [ID_W-1:0]       map_id;
  logic                  found;
  logic [ID_W-1:0]       free_id;
  logic                  free_ok;
  logic [IDX_W+POS_W-1:0] pop_ext;
  logic [IDX_W+POS_W-1:0] cnt_ext;

  // chain of list cells, cell 0 is the head
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [ID_W-1:0] right_id;
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_id = id_chain[0];
    end else begin : g_mid
      assign right_id = id_chain[g+1];
    end
    sfht_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .len_i      (count_q),
      .right_id_i (right_id),
      .head_id_i  (id_chain[0]),
      .id_o       (id_chain[g])
    );
  end

  // live id bitmap
  sfht_id_map u_id_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .set_i     (map_set),
    .clr_i     (map_clr),
    .wr_id_i   (map_id),
    .key_i     (key_q),
    .found_o   (found),
    .free_id_o (free_id),
    .free_ok_o (free_ok)
  );

  assign head_hit = (id_chain[0] == key_q);
  assign pop_ext  = {{POS_W{1'b0}}, pop_q};
  assign cnt_ext  = {{POS_W{1'b0}}, count_q[IDX_W-1:0]};
  assign map_id   = (state_q == S_SCAN) ? key_q : free_id;

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    count_d     = count_q;
    remain_d    = remain_q;
    pop_d       = pop_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    result_id_d = result_id_q;
    position_d  = position_q;
    cell_ctrl   = '0;
    map_set     = 1'b0;
    map_clr     = 1'b0;

    // output beat taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          key_d   = handle_id_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_id_d  = key_q;
        res_pos_d = '0;
        res_st_d  = sfht_pkg::ST_NOT_FOUND;
        state_d   = S_FINISH;
        case (op_q)
          sfht_pkg::OP_ALLOC: begin
            res_id_d = '0;
            res_st_d = sfht_pkg::ST_FULL;
            if ((count_q != CNT_W'(MAX_ENTRIES)) && free_ok) begin
              cell_ctrl.append = 1'b1;
              cell_ctrl.wr_id  = free_id;
              map_set          = 1'b1;
              res_id_d         = free_id;
              res_st_d         = sfht_pkg::ST_OK;
              res_pos_d        = cnt_ext[POS_W-1:0];
              count_d          = count_q + CNT_W'(1);
            end
          end
          sfht_pkg::OP_RELEASE, sfht_pkg::OP_LOOKUP: begin
            if (found) begin
              pop_d    = '0;
              remain_d = count_q;
              state_d  = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cell_ctrl.step = 1'b1;
        cell_ctrl.keep = !(head_hit && (op_q == sfht_pkg::OP_RELEASE));
        if (head_hit) begin
          res_st_d = sfht_pkg::ST_OK;
          if (op_q == sfht_pkg::OP_LOOKUP) begin
            res_pos_d = pop_ext[POS_W-1:0];
          end else begin
            map_clr = 1'b1;
            count_d = count_q - CNT_W'(1);
          end
        end
        pop_d    = pop_q + IDX_W'(1);
        remain_d = remain_q - CNT_W'(1);
        if (remain_q == CNT_W'(1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_st_q;
          result_id_d = res_id_q;
          position_d  = res_pos_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      key_q       <= '0;
      count_q     <= '0;
      remain_q    <= '0;
      pop_q       <= '0;
      res_st_q    <= '0;
      res_id_q    <= '0;
      res_pos_q   <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      result_id_q <= '0;
      position_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      key_q       <= key_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      pop_q       <= pop_d;
      res_st_q    <= res_st_d;
      res_id_q    <= res_id_d;
      res_pos_q   <= res_pos_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      result_id_q <= result_id_d;
      position_q  <= position_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_id_o = result_id_q;
  assign position_o  = position_q;

  // live count stays within the chain
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // a rotation only runs over a nonempty list
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((count_q != '0) && (remain_q != '0)))
    else $error("rotation over empty list");

  // a released id leaves the list, so the next head cannot match it
  a_release_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && head_hit && op_q == sfht_pkg::OP_RELEASE)
    |=> !(state_q == S_SCAN && head_hit))
    else $error("released id still in list");

  // a full answer carries id zero
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == sfht_pkg::ST_FULL) |-> (result_id_q == '0))
    else $error("full status with nonzero id");

endmodule

@@ hdl/sfht_cell.sv @@
// sfht_cell: one entry of the live id list, shifts toward the head on a step
// depends on: sfht_pkg
module sfht_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                     clk_i,
  input  sfht_pkg::cell_ctrl_t     ctrl_i,
  input  logic [CNT_W-1:0]         len_i,
  input  logic [sfht_pkg::ID_W-1:0] right_id_i,
  input  logic [sfht_pkg::ID_W-1:0] head_id_i,
  output logic [sfht_pkg::ID_W-1:0] id_o
);

  logic [sfht_pkg::ID_W-1:0] id_q, id_d;
  logic                      is_tail;
  logic                      is_next;

  // position of this cell relative to the live length
  assign is_tail = (len_i == CNT_W'(IDX + 1));
  assign is_next = (len_i == CNT_W'(IDX));

  // next entry value
  always_comb begin
    id_d = id_q;
    if (ctrl_i.step) begin
      if (ctrl_i.keep && is_tail) begin
        id_d = head_id_i;
      end else begin
        id_d = right_id_i;
      end
    end else if (ctrl_i.append && is_next) begin
      id_d = ctrl_i.wr_id;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;

endmodule

@@ hdl/sfht_id_map.sv @@
// sfht_id_map: bitmap of live ids, membership test and smallest free id
// depends on: sfht_pkg
module sfht_id_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      set_i,
  input  logic                      clr_i,
  input  logic [sfht_pkg::ID_W-1:0] wr_id_i,
  input  logic [sfht_pkg::ID_W-1:0] key_i,
  output logic                      found_o,
  output logic [sfht_pkg::ID_W-1:0] free_id_o,
  output logic                      free_ok_o
);

  logic [sfht_pkg::ID_SPACE-1:0] used_q, used_d;
  logic [sfht_pkg::ID_W-1:0]     free_q, free_d;
  logic                          free_ok_q, free_ok_d;

  // bitmap update
  always_comb begin
    used_d = used_q;
    if (set_i) begin
      used_d[wr_id_i] = 1'b1;
    end
    if (clr_i) begin
      used_d[wr_id_i] = 1'b0;
    end
  end

  // lowest clear bit above zero, registered
  always_comb begin
    free_d    = '0;
    free_ok_d = 1'b0;
    for (int i = sfht_pkg::ID_SPACE - 1; i >= 1; i--) begin
      if (!used_q[i]) begin
        free_d    = sfht_pkg::ID_W'(i);
        free_ok_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      free_q    <= sfht_pkg::ID_W'(1);
      free_ok_q <= 1'b1;
    end else begin
      used_q    <= used_d;
      free_q    <= free_d;
      free_ok_q <= free_ok_d;
    end
  end

  assign found_o   = used_q[key_i];
  assign free_id_o = free_q;
  assign free_ok_o = free_ok_q;

  // id zero is never live
  a_zero_unused: assert property (@(posedge clk_i) disable iff (!rst_ni) !used_q[0])
    else $error("id zero marked live");

  // a set always carries a nonzero id
  a_set_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_i |-> (wr_id_i != '0))
    else $error("allocation of id zero");

  // set and clear never in the same cycle
  a_set_clr: assert property (@(posedge clk_i) disable iff (!rst_ni) !(set_i && clr_i))
    else $error("bitmap set and clear together");

endmodule
